// ----- hw/rtl/arpc_pkg.sv -----
// ============================================================================
// arpc_pkg - shared types and constants of the address range profile counter
// Field widths of the command and response items, operation codes, the item
// structs passed between the sequencer and the top level, and the compare
// status of the shared range compare unit.
// ============================================================================
package arpc_pkg;

	localparam int MODE_W    = 2;
	localparam int IDX_W     = 8;
	localparam int PORT_AW   = 32;
	localparam int CNT_W     = 32;
	localparam int ENTRIES_W = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [IDX_W-1:0]   entry_index;
		logic [PORT_AW-1:0] entry_start;
		logic [PORT_AW-1:0] entry_size;
		logic [PORT_AW-1:0] sample_addr;
	} cmd_t;

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_index;
		logic               at_entry_point;
		logic [PORT_AW-1:0] read_start;
		logic [PORT_AW-1:0] read_size;
		logic [CNT_W-1:0]   read_instr_count;
		logic [CNT_W-1:0]   read_call_count;
		logic [CNT_W-1:0]   total_count;
		logic [CNT_W-1:0]   other_count;
	} res_t;

	typedef struct packed {
		logic below;
		logic in_range;
		logic at_start;
	} cmp_t;

endpackage

// ----- hw/rtl/arpc_if.sv -----
// ============================================================================
// arpc_if - valid/ready channels of the address range profile counter
// arpc_cmd_if carries command items into the block, arpc_rsp_if carries the
// response items out of it.
// ============================================================================
interface arpc_cmd_if import arpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [IDX_W-1:0]   entry_index;
	logic [PORT_AW-1:0] entry_start;
	logic [PORT_AW-1:0] entry_size;
	logic [PORT_AW-1:0] sample_addr;

	modport source (
		output valid, mode, entry_index, entry_start, entry_size, sample_addr,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_index, entry_start, entry_size, sample_addr,
		output ready
	);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [IDX_W-1:0]   hit_index;
	logic               at_entry_point;
	logic [PORT_AW-1:0] read_start;
	logic [PORT_AW-1:0] read_size;
	logic [CNT_W-1:0]   read_instr_count;
	logic [CNT_W-1:0]   read_call_count;
	logic [CNT_W-1:0]   total_count;
	logic [CNT_W-1:0]   other_count;

	modport source (
		output valid, hit, hit_index, at_entry_point, read_start, read_size,
		       read_instr_count, read_call_count, total_count, other_count,
		input  ready
	);
	modport sink (
		input  valid, hit, hit_index, at_entry_point, read_start, read_size,
		       read_instr_count, read_call_count, total_count, other_count,
		output ready
	);
endinterface

// ----- hw/rtl/arpc_cmp.sv -----
// ============================================================================
// arpc_cmp - shared range compare unit
// Classifies one address against one range: below the start, inside
// [start, start + size), and equal to the start.
// ============================================================================
module arpc_cmp import arpc_pkg::*; #(
	parameter int AW = 32
) (
	input  logic [AW-1:0] addr,
	input  logic [AW-1:0] start,
	input  logic [AW-1:0] size,
	output cmp_t          res
);

	logic [AW-1:0] offset;

	assign offset = addr - start;

	always_comb begin
		res.below    = (addr < start);
		// an empty range matches nothing, since offset < 0 never holds
		res.in_range = !res.below && (offset < size);
		res.at_start = (addr == start);
	end

endmodule

// ----- hw/rtl/arpc_seq.sv -----
// ============================================================================
// arpc_seq - range table and search sequencer
// Holds the range table in one memory, runs the binary search one probe per
// cycle through the shared compare unit, does the counter update on a hit and
// keeps the total and unmatched counters.
// ============================================================================
module arpc_seq import arpc_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	input  logic [ENTRIES_W-1:0] entries_in_use,
	output logic                 res_valid,
	input  logic                 res_take,
	output res_t                 res
);

	localparam int AW   = (ADDR_WIDTH < PORT_AW) ? ADDR_WIDTH : PORT_AW;
	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int NW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (NW > ENTRIES_W) ? NW : ENTRIES_W;
	localparam int MW   = 2 * AW + 2 * CNT_W;
	localparam logic [CMPW-1:0] TD_X = CMPW'(TABLE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SRCH = 5'b00010,
		S_READ = 5'b00100,
		S_DONE = 5'b01000,
		S_SPARE = 5'b10000
	} seq_state_t;

	seq_state_t state_q, state_n;

	logic [MW-1:0]    mem [TABLE_DEPTH];
	logic [MW-1:0]    rd_q;
	logic             we, re;
	logic [IW-1:0]    waddr, raddr;
	logic [MW-1:0]    wdata;

	logic [AW-1:0]    rd_start, rd_size;
	logic [CNT_W-1:0] rd_icnt, rd_ccnt;

	logic [AW-1:0]    addr_q;
	logic [NW-1:0]    lo_q, hi_q, mid_q;
	logic [NW-1:0]    lo_n, hi_n, mid_n;
	logic [NW:0]      mid_sum;
	logic             probe;
	logic [IW-1:0]    slot_q;
	res_t             res_q;
	logic [CNT_W-1:0] total_q, other_q;
	logic             tot_inc, oth_inc;

	logic [CMPW-1:0]  idx_x, eiu_x, n_x;
	logic [NW-1:0]    n_cnt;
	logic [IW-1:0]    idx_a;
	logic             load_ok, read_ok;
	cmp_t             cmp_res;

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rd_start = rd_q[MW-1 -: AW];
	assign rd_size  = rd_q[2*CNT_W+AW-1 -: AW];
	assign rd_icnt  = rd_q[2*CNT_W-1 -: CNT_W];
	assign rd_ccnt  = rd_q[CNT_W-1:0];

	arpc_cmp #(.AW(AW)) u_cmp (
		.addr  (addr_q),
		.start (rd_start),
		.size  (rd_size),
		.res   (cmp_res)
	);

	// Clamp the searched entry count to the table depth
	assign idx_x   = CMPW'(cmd.entry_index);
	assign eiu_x   = CMPW'(entries_in_use);
	assign n_x     = (eiu_x > TD_X) ? TD_X : eiu_x;
	assign n_cnt   = n_x[NW-1:0];
	assign idx_a   = idx_x[IW-1:0];
	assign load_ok = (idx_x < TD_X);
	assign read_ok = (idx_x < n_x);
	assign slot_q  = mid_q[IW-1:0];

	// Next search window
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (state_q == S_IDLE) begin
			lo_n = '0;
			hi_n = n_cnt;
		end else if (state_q == S_SRCH) begin
			if (cmp_res.below) begin
				hi_n = mid_q;
			end else begin
				lo_n = mid_q + NW'(1);
			end
		end
	end

	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = mid_sum[NW:1];
	assign probe   = (lo_n < hi_n);

	always_comb begin
		state_n = state_q;
		we      = 1'b0;
		waddr   = idx_a;
		wdata   = {cmd.entry_start[AW-1:0], cmd.entry_size[AW-1:0], {(2*CNT_W){1'b0}}};
		re      = 1'b0;
		raddr   = mid_n[IW-1:0];
		tot_inc = 1'b0;
		oth_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (mode_t'(cmd.mode))
						MODE_LOAD: begin
							we      = load_ok;
							state_n = S_DONE;
						end
						MODE_SAMPLE: begin
							if (probe) begin
								re      = 1'b1;
								state_n = S_SRCH;
							end else begin
								tot_inc = 1'b1;
								oth_inc = 1'b1;
								state_n = S_DONE;
							end
						end
						MODE_READ: begin
							if (read_ok) begin
								re      = 1'b1;
								raddr   = idx_a;
								state_n = S_READ;
							end else begin
								state_n = S_DONE;
							end
						end
						default: begin
							state_n = S_DONE;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (cmp_res.in_range) begin
					// hit: bump the counters of the probed entry in place
					we      = 1'b1;
					waddr   = slot_q;
					wdata   = {rd_start, rd_size, rd_icnt + CNT_W'(1),
					           rd_ccnt + CNT_W'(cmp_res.at_start)};
					tot_inc = 1'b1;
					state_n = S_DONE;
				end else if (probe) begin
					re = 1'b1;
				end else begin
					tot_inc = 1'b1;
					oth_inc = 1'b1;
					state_n = S_DONE;
				end
			end
			S_READ: begin
				state_n = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			other_q <= '0;
		end else begin
			state_q <= state_n;
			if (tot_inc) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (oth_inc) begin
				other_q <= other_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			res_q  <= '0;
			addr_q <= cmd.sample_addr[AW-1:0];
		end
		if ((state_q == S_IDLE && cmd_valid) || state_q == S_SRCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (state_q == S_SRCH && cmp_res.in_range) begin
			res_q.hit            <= 1'b1;
			res_q.hit_index      <= IDX_W'(slot_q);
			res_q.at_entry_point <= cmp_res.at_start;
		end
		if (state_q == S_READ) begin
			res_q.read_start       <= PORT_AW'(rd_start);
			res_q.read_size        <= PORT_AW'(rd_size);
			res_q.read_instr_count <= rd_icnt;
			res_q.read_call_count  <= rd_ccnt;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res             = res_q;
		res.total_count = total_q;
		res.other_count = other_q;
	end

endmodule

// ----- hw/rtl/address_range_profile_counter.sv -----
// ============================================================================
// address_range_profile_counter - profiler over a table of address ranges
// Top level: configuration register, command unpacking, response register.
// ============================================================================
// Usage:
//   cmd carries one item per valid/ready handshake. mode selects the work:
//   load a table entry (start, size; its counts are cleared), sample an
//   instruction address, or read back an entry. rsp returns exactly one item
//   per command with hit status, read-back fields and both running totals.
//   cfg_we/cfg_wdata write entries_in_use, the number of entries searched
//   and readable; write it only while no command is in flight.
// Timing:
//   A sample runs a binary search with one table probe per cycle through a
//   shared compare unit, using P <= ceil(log2(n + 1)) probes for n searched
//   entries; the next command is accepted only once the sequencer has handed
//   off its result. A load goes straight to done, a read through a read-back
//   state. The response passes through the response register to rsp.
// Reset:
//   arst_n clears the sequencer, totals, response valid and entries_in_use.
//   Table contents are not cleared; load an entry before searching it.
// Stall:
//   A response waiting on rsp does not block the next command; a second
//   finished result holds in the sequencer until the register drains.
module address_range_profile_counter import arpc_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [ENTRIES_W-1:0] cfg_wdata,
	arpc_cmd_if.sink             cmd,
	arpc_rsp_if.source           rsp
);

	logic [ENTRIES_W-1:0] entries_in_use_q;
	cmd_t                 cmd_w;
	res_t                 res_w;
	res_t                 out_q;
	logic                 out_valid_q;
	logic                 res_valid;
	logic                 res_take;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (cfg_we) begin
			entries_in_use_q <= cfg_wdata;
		end
	end

	// Gather the command fields into one item
	always_comb begin
		cmd_w.mode        = cmd.mode;
		cmd_w.entry_index = cmd.entry_index;
		cmd_w.entry_start = cmd.entry_start;
		cmd_w.entry_size  = cmd.entry_size;
		cmd_w.sample_addr = cmd.sample_addr;
	end

	arpc_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd.valid),
		.cmd_ready      (cmd.ready),
		.cmd            (cmd_w),
		.entries_in_use (entries_in_use_q),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res            (res_w)
	);

	// Response register: take a new item when empty or draining this cycle
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res_w;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.hit              = out_q.hit;
	assign rsp.hit_index        = out_q.hit_index;
	assign rsp.at_entry_point   = out_q.at_entry_point;
	assign rsp.read_start       = out_q.read_start;
	assign rsp.read_size        = out_q.read_size;
	assign rsp.read_instr_count = out_q.read_instr_count;
	assign rsp.read_call_count  = out_q.read_call_count;
	assign rsp.total_count      = out_q.total_count;
	assign rsp.other_count      = out_q.other_count;

endmodule
